// ----- design/sle_pkg.sv -----
`timescale 1ns / 1ps

package sle_pkg;

  localparam int unsigned CAPACITY = 128;

  localparam int unsigned KW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = 8;
  localparam int unsigned XW = ((LW > PW) ? LW : PW) + 1;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned S_TDATA_W   = 72;
  localparam int unsigned S_TUSER_W   = 3;
  localparam int unsigned M_TDATA_W   = 56;
  localparam int unsigned M_TUSER_W   = 2;

  typedef logic signed [31:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_SEARCH = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_RANGE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_SHIFT,
    RING_SWAP
  } ring_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_COMPACT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    ring_mode_e mode;
    logic       parity;
  } ring_ctl_t;

  typedef struct packed {
    logic  keep;
    word_t data;
  } cell_t;

  typedef struct packed {
    logic          ok;
    logic          found;
    logic [PW-1:0] position;
    word_t         read_value;
    logic [7:0]    length;
    logic [7:0]    removed;
  } res_t;

endpackage

// ----- design/sle_cell.sv -----
`timescale 1ns / 1ps

module sle_cell (
  input  logic              clk_i,
  input  sle_pkg::ring_ctl_t ctl_i,
  input  logic              odd_i,
  input  sle_pkg::cell_t    up_i,
  input  sle_pkg::cell_t    dn_i,
  output sle_pkg::cell_t    q_o
);
  import sle_pkg::*;

  cell_t q_q;
  cell_t q_d;

  always_comb begin
    q_d = q_q;
    unique case (ctl_i.mode)
      RING_HOLD: begin
        q_d = q_q;
      end
      RING_SHIFT: begin
        q_d = up_i;
      end
      RING_SWAP: begin
        if (odd_i == ctl_i.parity) begin
          if (!q_q.keep && up_i.keep) q_d = up_i;
        end else begin
          if (!dn_i.keep && q_q.keep) q_d = dn_i;
        end
      end
      default: begin
        q_d = q_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

// ----- design/sle_ctrl.sv -----
`timescale 1ns / 1ps

module sle_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sle_pkg::OP_W-1:0]    in_op_i,
  input  logic [sle_pkg::PW-1:0]      in_pos_i,
  input  sle_pkg::word_t              in_val_i,
  input  sle_pkg::word_t              in_upr_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sle_pkg::res_t               out_o,
  output sle_pkg::ring_ctl_t          ctl_o,
  output sle_pkg::cell_t              tail_o,
  input  sle_pkg::word_t              head0_i,
  input  sle_pkg::word_t              head1_i
);
  import sle_pkg::*;

  state_e         state_q, state_d;
  logic [KW-1:0]  k_q;
  logic [LW-1:0]  len_q;
  logic [LW-1:0]  rem_q;
  logic [OP_W-1:0] op_q;
  logic [PW-1:0]  pos_q;
  word_t          val_q;
  word_t          upr_q;
  word_t          hold_q;
  logic           ok_q;
  logic           found_q;
  logic [PW-1:0]  pos_res_q;
  word_t          rdat_q;
  logic           m_valid_q;
  res_t           res_q;

  logic [XW-1:0]  pos_x, len_x, k_x, idx_x, kp1_x, len_new_x, rem_x;
  logic           in_list, ins_ok, pass, go_rot;
  logic           k_last, k_live, in_range, load, accept;
  logic [LW-1:0]  len_new;

  assign pos_x  = XW'(in_pos_i);
  assign len_x  = XW'(len_q);
  assign k_x    = XW'(k_q);
  assign idx_x  = XW'(pos_q) - XW'(1);
  assign kp1_x  = k_x + XW'(1);
  assign k_last = (k_q == KW'(CAPACITY - 1));
  assign k_live = (k_x < len_x);
  assign in_range = ($signed(head0_i) >= $signed(val_q)) &&
                    ($signed(head0_i) <= $signed(upr_q));
  assign accept = in_valid_i && in_ready_o;
  assign load   = (state_q == ST_FINISH) && (!m_valid_q || out_ready_i);

  assign in_list = (pos_x != '0) && (pos_x <= len_x);
  assign ins_ok  = (pos_x != '0) && (pos_x <= len_x + XW'(1)) && (len_x < XW'(CAPACITY));

  always_comb begin
    unique case (in_op_i)
      OP_READ:   pass = in_list;
      OP_SEARCH: pass = 1'b1;
      OP_INSERT: pass = ins_ok;
      OP_DELETE: pass = in_list;
      OP_RANGE:  pass = 1'b1;
      default:   pass = 1'b0;
    endcase
  end
  assign go_rot = pass;

  always_comb begin
    len_new = len_q;
    if (ok_q) begin
      unique case (op_q)
        OP_INSERT: len_new = len_q + LW'(1);
        OP_DELETE: len_new = len_q - LW'(1);
        OP_RANGE:  len_new = len_q - rem_q;
        default:   len_new = len_q;
      endcase
    end
  end
  assign len_new_x = XW'(len_new);
  assign rem_x     = XW'(rem_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = go_rot ? ST_ROTATE : ST_FINISH;
      end
      ST_ROTATE: begin
        if (k_last) state_d = (op_q == OP_RANGE) ? ST_COMPACT : ST_FINISH;
      end
      ST_COMPACT: begin
        if (k_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    ctl_o.mode    = RING_HOLD;
    ctl_o.parity  = k_q[0];
    tail_o.data   = head0_i;
    tail_o.keep   = 1'b1;
    unique case (state_q)
      ST_ROTATE: begin
        ctl_o.mode = RING_SHIFT;
        unique case (op_q)
          OP_INSERT: begin
            if (k_x == idx_x) tail_o.data = val_q;
            else if (k_x > idx_x) tail_o.data = hold_q;
          end
          OP_DELETE: begin
            if (k_x >= idx_x) tail_o.data = head1_i;
          end
          OP_RANGE: begin
            tail_o.keep = k_live && !in_range;
          end
          default: begin
            tail_o.data = head0_i;
          end
        endcase
      end
      ST_COMPACT: begin
        ctl_o.mode  = RING_SWAP;
        tail_o.keep = 1'b0;
      end
      default: begin
        ctl_o.mode = RING_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      len_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ROTATE || state_q == ST_COMPACT) begin
        k_q <= k_last ? '0 : k_q + KW'(1);
      end else begin
        k_q <= '0;
      end
      if (load) len_q <= len_new;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= in_op_i;
      pos_q     <= in_pos_i;
      val_q     <= in_val_i;
      upr_q     <= in_upr_i;
      ok_q      <= pass;
      found_q   <= 1'b0;
      rdat_q    <= '0;
      rem_q     <= '0;
      pos_res_q <= (in_op_i == OP_DELETE && pass) ? in_pos_i : '0;
    end
    if (state_q == ST_ROTATE) begin
      unique case (op_q)
        OP_READ: begin
          if (k_x == idx_x) rdat_q <= head0_i;
        end
        OP_SEARCH: begin
          if (k_live && !found_q && head0_i == val_q) begin
            found_q   <= 1'b1;
            pos_res_q <= kp1_x[PW-1:0];
          end
        end
        OP_INSERT: begin
          if (k_x >= idx_x) hold_q <= head0_i;
        end
        OP_RANGE: begin
          if (k_live && in_range) rem_q <= rem_q + LW'(1);
        end
        default: begin
          hold_q <= hold_q;
        end
      endcase
    end
    if (load) begin
      res_q.ok         <= ok_q;
      res_q.found      <= found_q;
      res_q.position   <= pos_res_q;
      res_q.read_value <= rdat_q;
      res_q.length     <= len_new_x[7:0];
      res_q.removed    <= rem_x[7:0];
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_o       = res_q;

endmodule

// ----- design/sequential_list_engine_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                               tuser
// s_axis    in   position, value, value_upper                     op
// m_axis    out  position_out, read_value, length_out, removed_count  ok, found
//
// Read, search, insert and delete rotate the cell ring once; range delete adds
// an odd-even compaction pass. Refused and unknown requests skip the ring and
// go straight to the result.
// Reset clears the length; cell contents stay undefined until written.
// A stalled result holds in the output register; the next transaction is taken
// as soon as the current one is placed there.

module sequential_list_engine_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sle_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // position, value, value_upper
  input  logic [sle_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // op
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sle_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // position_out, read_value,
                                                        // length_out, removed_count
  output logic [sle_pkg::M_TUSER_W-1:0]  m_axis_tuser   // ok, found
);
  import sle_pkg::*;

  cell_t     cell_q [CAPACITY];
  cell_t     tail;
  ring_ctl_t ctl;
  res_t      res;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_t up, dn;
      if (i == CAPACITY - 1) begin : g_top
        assign up = tail;
      end else begin : g_mid
        assign up = cell_q[i+1];
      end
      if (i == 0) begin : g_bot
        assign dn = '{keep: 1'b1, data: '0};
      end else begin : g_low
        assign dn = cell_q[i-1];
      end
      sle_cell u_cell (
        .clk_i (clk_i),
        .ctl_i (ctl),
        .odd_i (1'(i % 2)),
        .up_i  (up),
        .dn_i  (dn),
        .q_o   (cell_q[i])
      );
    end
  endgenerate

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_pos_i    (s_axis_tdata[7:0]),
    .in_val_i    (s_axis_tdata[39:8]),
    .in_upr_i    (s_axis_tdata[71:40]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .ctl_o       (ctl),
    .tail_o      (tail),
    .head0_i     (cell_q[0].data),
    .head1_i     (cell_q[1].data)
  );

  assign m_axis_tdata = {res.removed, res.length, res.read_value, res.position};
  assign m_axis_tuser = {res.found, res.ok};

endmodule

// ----- design/sle_checker.sv -----
`timescale 1ns / 1ps

module sle_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sle_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [sle_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import sle_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && m_axis_tdata[39:8] == '0)
    else $error("search hit without ok");

  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[55:48] != '0 |->
      m_axis_tuser[0] && !m_axis_tuser[1] && m_axis_tdata[7:0] == '0)
    else $error("removed count on a non range result");

endmodule

bind sequential_list_engine_top sle_checker u_sle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/sequential_list_engine_top_tb.sv -----
`timescale 1ns / 1ps

module sequential_list_engine_top_tb;
  import sle_pkg::*;

  localparam int RANDOM_REQS    = 1375;
  localparam int PHASE_LEN      = 150;
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 20;
  localparam int MAX_PRINTED    = 50;
  localparam int PHASE_FILL     = 0;
  localparam int PHASE_MIXED    = 1;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [PW-1:0]   position;
    word_t           value;
    word_t           value_upper;
  } list_req_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // position, value, value_upper
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // position_out, read_value, length_out, removed_count
  logic [M_TUSER_W-1:0] m_axis_tuser;        // ok, found

  list_req_t pending_reqs[$];
  res_t      expected_results[$];
  list_req_t cur_req;
  list_req_t next_req;
  word_t     list_mem [CAPACITY];
  int        list_len     = 0;
  int        err_cnt      = 0;
  int        gap_left     = 0;
  int        stall_left   = 0;
  int        ready_hold   = 0;
  int        idle_cycles  = 0;
  bit        calm         = 1'b0;

  sequential_list_engine_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (err_cnt < MAX_PRINTED) begin
      $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, field, got, want);
    end
    err_cnt++;
  endtask

  function automatic int draw_idle();
    if (calm || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic res_t apply_list_op(list_req_t req);
    res_t r;
    int   p;
    int   j;
    int   kept;
    r = '0;
    p = int'(req.position);
    case (req.op)
      OP_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.ok = 1'b1;
          r.read_value = list_mem[p - 1];
        end
      end
      OP_SEARCH: begin
        r.ok = 1'b1;
        for (j = 0; j < list_len; j++) begin
          if (list_mem[j] == req.value) begin
            r.found = 1'b1;
            r.position = PW'(j + 1);
            break;
          end
        end
      end
      OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
          for (j = list_len; j > p - 1; j--) begin
            list_mem[j] = list_mem[j - 1];
          end
          list_mem[p - 1] = req.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          for (j = p; j < list_len; j++) begin
            list_mem[j - 1] = list_mem[j];
          end
          list_len--;
          r.ok = 1'b1;
          r.position = req.position;
        end
      end
      OP_RANGE: begin
        kept = 0;
        for (j = 0; j < list_len; j++) begin
          if (!(list_mem[j] >= req.value && list_mem[j] <= req.value_upper)) begin
            list_mem[kept] = list_mem[j];
            kept++;
          end
        end
        r.ok = 1'b1;
        r.removed = 8'(list_len - kept);
        list_len = kept;
      end
      default: begin
      end
    endcase
    r.length = 8'(list_len);
    return r;
  endfunction

  function automatic list_req_t next_list_req(int phase);
    list_req_t q;
    int        pick;
    int        len;
    len = list_len;
    q.position = PW'($urandom_range(0, 255));
    q.value_upper = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      q.value = word_t'($urandom_range(0, 16)) - 8;
    end else if (pick == 4) begin
      q.value = 32'h7FFF_FFFF;
    end else if (pick == 5) begin
      q.value = 32'h8000_0000;
    end else begin
      q.value = $urandom;
    end
    if ($urandom_range(0, 99) < 2) begin
      q.op = OP_W'($urandom_range(5, 7));
      return q;
    end
    pick = $urandom_range(0, 99);
    case (phase)
      PHASE_FILL:
        q.op = (pick < 88) ? OP_INSERT : (pick < 94) ? OP_READ : OP_SEARCH;
      PHASE_MIXED:
        q.op = (pick < 30) ? OP_INSERT : (pick < 45) ? OP_DELETE :
               (pick < 70) ? OP_READ : (pick < 90) ? OP_SEARCH : OP_RANGE;
      default:
        q.op = (pick < 50) ? OP_DELETE : (pick < 62) ? OP_RANGE :
               (pick < 80) ? OP_READ : (pick < 92) ? OP_SEARCH : OP_INSERT;
    endcase
    if ($urandom_range(0, 9) != 0) begin
      if (q.op == OP_INSERT) begin
        q.position = PW'($urandom_range(1, len + 1));
      end else if (len > 0) begin
        q.position = PW'($urandom_range(1, len));
      end
    end
    if (len > 0 && q.op != OP_INSERT && $urandom_range(0, 1) == 1) begin
      q.value = list_mem[$urandom_range(0, len - 1)];
    end
    if (q.op == OP_RANGE) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        q.value_upper = q.value + word_t'($urandom_range(0, 3));
      end else if (pick == 7) begin
        q.value_upper = q.value - word_t'($urandom_range(1, 5));
      end
    end
    return q;
  endfunction

  task automatic queue_req(logic [OP_W-1:0] op, int pos, word_t val, word_t upper);
    list_req_t q;
    q.op = op;
    q.position = PW'(pos);
    q.value = val;
    q.value_upper = upper;
    pending_reqs.push_back(q);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_list_op(cur_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          cur_req <= next_req;
          s_axis_tdata <= {next_req.value_upper, next_req.value, next_req.position};
          s_axis_tuser <= next_req.op;
          s_axis_tvalid <= 1'b1;
          gap_left <= draw_idle();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[39:8], '0);
        end else begin
          res_t want;
          want = expected_results.pop_front();
          if (m_axis_tuser[0] !== want.ok) begin
            report_mismatch("ok", 32'(m_axis_tuser[0]), 32'(want.ok));
          end
          if (m_axis_tuser[1] !== want.found) begin
            report_mismatch("found", 32'(m_axis_tuser[1]), 32'(want.found));
          end
          if (m_axis_tdata[7:0] !== want.position) begin
            report_mismatch("position_out", 32'(m_axis_tdata[7:0]), 32'(want.position));
          end
          if (m_axis_tdata[39:8] !== want.read_value) begin
            report_mismatch("read_value", m_axis_tdata[39:8], want.read_value);
          end
          if (m_axis_tdata[47:40] !== want.length) begin
            report_mismatch("length_out", 32'(m_axis_tdata[47:40]), 32'(want.length));
          end
          if (m_axis_tdata[55:48] !== want.removed) begin
            report_mismatch("removed_count", 32'(m_axis_tdata[55:48]), 32'(want.removed));
          end
        end
        ready_hold = draw_idle();
        if (ready_hold != 0) begin
          m_axis_tready <= 1'b0;
          stall_left <= ready_hold - 1;
        end
      end else if (!m_axis_tready) begin
        if (stall_left == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          stall_left <= stall_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_req(OP_READ, 1, 0, 0);
    queue_req(OP_READ, 0, 0, 0);
    queue_req(OP_SEARCH, 0, 0, 0);
    queue_req(OP_DELETE, 1, 0, 0);
    queue_req(OP_INSERT, 0, 1, 0);
    queue_req(OP_INSERT, 2, 1, 0);
    queue_req(OP_INSERT, 1, 32'h7FFF_FFFF, 0);
    queue_req(OP_INSERT, 1, 32'h8000_0000, 0);
    queue_req(OP_INSERT, 3, 0, 0);
    queue_req(OP_INSERT, 2, -1, 0);
    queue_req(OP_READ, 1, 0, 0);
    queue_req(OP_READ, 4, 0, 0);
    queue_req(OP_READ, 5, 0, 0);
    queue_req(OP_READ, 255, 0, 0);
    queue_req(OP_SEARCH, 0, 32'h8000_0000, 0);
    queue_req(OP_SEARCH, 0, 12345, 0);
    queue_req(OP_RANGE, 0, 5, -5);
    queue_req(OP_RANGE, 0, -1, 0);
    queue_req(OP_DELETE, 255, 0, 0);
    queue_req(OP_DELETE, 2, 0, 0);
    queue_req(3'd5, 17, $urandom, $urandom);
    queue_req(3'd6, 255, $urandom, $urandom);
    queue_req(3'd7, 0, $urandom, $urandom);
    queue_req(OP_RANGE, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(OP_INSERT, 1, 32'h5A5A_A5A5, 0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      while (pending_reqs.size() != 0) @(negedge clk_i);
      calm = ((n % PHASE_LEN) >= 60) && ((n % PHASE_LEN) < 90);
      pending_reqs.push_back(next_list_req((n / PHASE_LEN) % 3));
    end
    calm = 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("missing results", expected_results.size(), 0);
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
